/* src/minv3_pkg.sv */
// Package for the 3x3 matrix inverse pipeline.
// Holds the fixed-point widths and the item types of both channels.
// Used by matrix3x3_inverse; depends on nothing else.
package minv3_pkg;

    // Input entries are signed Q8.8 and results are signed Q16.16.
    localparam int IN_W     = 16;
    localparam int IN_FRAC  = 8;
    localparam int OUT_W    = 32;
    localparam int OUT_FRAC = 16;

    // Widths of the intermediate values; every one of them is exact.
    localparam int PROD_W = 2 * IN_W;
    localparam int COF_W  = PROD_W + 1;
    localparam int TERM_W = IN_W + COF_W;
    localparam int DET_W  = TERM_W + 2;
    localparam int SHIFT  = IN_FRAC + OUT_FRAC;
    localparam int NUM_W  = COF_W + SHIFT;
    localparam int CMP_W  = DET_W + OUT_W;
    localparam int LANES  = 9;

    typedef struct packed {
        logic signed [IN_W-1:0] in_r0c0;
        logic signed [IN_W-1:0] in_r0c1;
        logic signed [IN_W-1:0] in_r0c2;
        logic signed [IN_W-1:0] in_r1c0;
        logic signed [IN_W-1:0] in_r1c1;
        logic signed [IN_W-1:0] in_r1c2;
        logic signed [IN_W-1:0] in_r2c0;
        logic signed [IN_W-1:0] in_r2c1;
        logic signed [IN_W-1:0] in_r2c2;
    } in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] inv_r0c0;
        logic signed [OUT_W-1:0] inv_r0c1;
        logic signed [OUT_W-1:0] inv_r0c2;
        logic signed [OUT_W-1:0] inv_r1c0;
        logic signed [OUT_W-1:0] inv_r1c1;
        logic signed [OUT_W-1:0] inv_r1c2;
        logic signed [OUT_W-1:0] inv_r2c0;
        logic signed [OUT_W-1:0] inv_r2c1;
        logic signed [OUT_W-1:0] inv_r2c2;
        logic                    singular;
    } out_t;

endpackage

/* src/matrix3x3_inverse.sv */
// Pipelined 3x3 matrix inverse by the adjugate, with a saturating divider.
// Depends on minv3_pkg for widths and item types.
//
//   channel | valid     | stall     | payload        | item
//   input   | mat_valid | mat_stall | mat (in_t)     | one Q8.8 matrix
//   output  | inv_valid | inv_stall | inv (out_t)    | Q16.16 inverse and singular flag
//
// One item is taken every cycle while the output buffer has room. An item passes
// through five stages for cofactors, determinant and signs, one range check stage,
// one stage per quotient bit of the restoring divider, then saturation into the
// output buffer.
// Reset clears the valid bits and empties the output buffer; payload is not reset.
// The whole pipeline advances while the two-entry output buffer has room,
// so an item is taken even while a finished result waits at the output.
module matrix3x3_inverse (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            mat_valid,
    output logic            mat_stall,
    input  minv3_pkg::in_t  mat,
    output logic            inv_valid,
    input  logic            inv_stall,
    output minv3_pkg::out_t inv
);
    import minv3_pkg::*;

    logic en;
    logic [1:0] cnt_reg, cnt_next;
    logic push, pop;

    logic signed [IN_W-1:0] a [0:2][0:2];

    // Stage 1..5 registers.
    logic                     v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [PROD_W-1:0] pa1_reg [0:LANES-1];
    logic signed [PROD_W-1:0] pb1_reg [0:LANES-1];
    logic signed [IN_W-1:0]   r01_reg [0:2];
    logic signed [IN_W-1:0]   r02_reg [0:2];
    logic signed [COF_W-1:0]  c2_reg  [0:LANES-1];
    logic signed [COF_W-1:0]  c3_reg  [0:LANES-1];
    logic signed [COF_W-1:0]  c4_reg  [0:LANES-1];
    logic signed [TERM_W-1:0] t3_reg  [0:2];
    logic signed [DET_W-1:0]  det4_reg;
    logic [COF_W-1:0]         nmag5_reg [0:LANES-1];
    logic                     neg5_reg  [0:LANES-1];
    logic [DET_W-1:0]         dmag5_reg;
    logic                     sing5_reg;

    // Divider stage registers; index 0 is loaded by the range check stage.
    logic                     vd_reg   [0:OUT_W];
    logic [DET_W-1:0]         dd_reg   [0:OUT_W];
    logic                     sd_reg   [0:OUT_W];
    logic [NUM_W-1:0]         rem_reg  [0:OUT_W][0:LANES-1];
    logic [OUT_W-1:0]         q_reg    [0:OUT_W][0:LANES-1];
    logic                     neg_reg  [0:OUT_W][0:LANES-1];
    logic                     sat_reg  [0:OUT_W][0:LANES-1];

    logic signed [OUT_W-1:0]  res [0:LANES-1];
    out_t                     res_item;
    out_t                     buf_reg [0:1];
    logic                     wr_ptr_reg, rd_ptr_reg;

    // Pipeline advances while the output buffer has room.
    assign en        = (cnt_reg != 2'd2);
    assign mat_stall = ~en;

    // Unpack the input item into a matrix.
    always_comb
    begin
        a[0][0] = mat.in_r0c0; a[0][1] = mat.in_r0c1; a[0][2] = mat.in_r0c2;
        a[1][0] = mat.in_r1c0; a[1][1] = mat.in_r1c1; a[1][2] = mat.in_r1c2;
        a[2][0] = mat.in_r2c0; a[2][1] = mat.in_r2c1; a[2][2] = mat.in_r2c2;
    end

    // Valid bits of the front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0;
            v4_reg <= 1'b0; v5_reg <= 1'b0; vd_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= mat_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            vd_reg[0] <= v5_reg;
        end
    end

    genvar gi, gk, gs;
    generate
        // Cofactor products and differences, one lane per cofactor (i,k).
        for (gi = 0; gi < 3; gi++)
        begin : g_row
            for (gk = 0; gk < 3; gk++)
            begin : g_col
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        pa1_reg[gi*3+gk] <= PROD_W'(a[(gi+1)%3][(gk+1)%3])
                                          * PROD_W'(a[(gi+2)%3][(gk+2)%3]);
                        pb1_reg[gi*3+gk] <= PROD_W'(a[(gi+1)%3][(gk+2)%3])
                                          * PROD_W'(a[(gi+2)%3][(gk+1)%3]);
                        c2_reg[gi*3+gk]  <= COF_W'(pa1_reg[gi*3+gk])
                                          - COF_W'(pb1_reg[gi*3+gk]);
                        c3_reg[gi*3+gk]  <= c2_reg[gi*3+gk];
                        c4_reg[gi*3+gk]  <= c3_reg[gi*3+gk];
                    end
                end
            end
        end

        // Determinant terms along row 0.
        for (gk = 0; gk < 3; gk++)
        begin : g_term
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r01_reg[gk] <= a[0][gk];
                    r02_reg[gk] <= r01_reg[gk];
                    t3_reg[gk]  <= TERM_W'(r02_reg[gk]) * TERM_W'(c2_reg[gk]);
                end
            end
        end

        // Output lane j = r*3+k takes cofactor (k,r): sign, magnitude, range check.
        for (gi = 0; gi < 3; gi++)
        begin : g_orow
            for (gk = 0; gk < 3; gk++)
            begin : g_ocol
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        neg5_reg[gi*3+gk]  <= c4_reg[gk*3+gi][COF_W-1]
                                            ^ det4_reg[DET_W-1];
                        nmag5_reg[gi*3+gk] <= c4_reg[gk*3+gi][COF_W-1]
                                            ? COF_W'(-c4_reg[gk*3+gi])
                                            : COF_W'(c4_reg[gk*3+gi]);
                        sat_reg[0][gi*3+gk] <= ((CMP_W'(nmag5_reg[gi*3+gk]) << SHIFT)
                                               >= (CMP_W'(dmag5_reg) << OUT_W));
                        rem_reg[0][gi*3+gk] <= NUM_W'(nmag5_reg[gi*3+gk]) << SHIFT;
                        q_reg[0][gi*3+gk]   <= '0;
                        neg_reg[0][gi*3+gk] <= neg5_reg[gi*3+gk];
                    end
                end
            end
        end

        // One quotient bit per stage, most significant first.
        for (gs = 0; gs < OUT_W; gs++)
        begin : g_div
            localparam int B = OUT_W - 1 - gs;
            logic [CMP_W-1:0] dsh;
            assign dsh = CMP_W'(dd_reg[gs]) << B;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vd_reg[gs+1] <= 1'b0;
                else if (en)
                    vd_reg[gs+1] <= vd_reg[gs];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dd_reg[gs+1] <= dd_reg[gs];
                    sd_reg[gs+1] <= sd_reg[gs];
                end
            end

            for (gk = 0; gk < LANES; gk++)
            begin : g_lane
                logic             ge;
                logic [CMP_W-1:0] diff;
                assign ge   = (CMP_W'(rem_reg[gs][gk]) >= dsh);
                assign diff = CMP_W'(rem_reg[gs][gk]) - dsh;
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[gs+1][gk] <= ge ? NUM_W'(diff) : rem_reg[gs][gk];
                        q_reg[gs+1][gk]   <= q_reg[gs][gk] | (OUT_W'(ge) << B);
                        neg_reg[gs+1][gk] <= neg_reg[gs][gk];
                        sat_reg[gs+1][gk] <= sat_reg[gs][gk];
                    end
                end
            end
        end

        // Saturate, apply the sign and clear entries of a singular matrix.
        for (gk = 0; gk < LANES; gk++)
        begin : g_sat
            logic [OUT_W-1:0] cap;
            logic [OUT_W-1:0] mq;
            always_comb
            begin
                cap = neg_reg[OUT_W][gk] ? {1'b1, {(OUT_W-1){1'b0}}}
                                         : {1'b0, {(OUT_W-1){1'b1}}};
                mq  = (sat_reg[OUT_W][gk] || (q_reg[OUT_W][gk] > cap))
                      ? cap : q_reg[OUT_W][gk];
                if (sd_reg[OUT_W])
                    res[gk] = '0;
                else if (neg_reg[OUT_W][gk])
                    res[gk] = OUT_W'(-mq);
                else
                    res[gk] = OUT_W'(mq);
            end
        end
    endgenerate

    // Determinant sum, its magnitude and the singular flag.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det4_reg  <= DET_W'(t3_reg[0]) + DET_W'(t3_reg[1]) + DET_W'(t3_reg[2]);
            dmag5_reg <= det4_reg[DET_W-1] ? DET_W'(-det4_reg) : DET_W'(det4_reg);
            sing5_reg <= (det4_reg == '0);
            dd_reg[0] <= dmag5_reg;
            sd_reg[0] <= sing5_reg;
        end
    end

    // Pack the result item.
    always_comb
    begin
        res_item.inv_r0c0 = res[0];
        res_item.inv_r0c1 = res[1];
        res_item.inv_r0c2 = res[2];
        res_item.inv_r1c0 = res[3];
        res_item.inv_r1c1 = res[4];
        res_item.inv_r1c2 = res[5];
        res_item.inv_r2c0 = res[6];
        res_item.inv_r2c1 = res[7];
        res_item.inv_r2c2 = res[8];
        res_item.singular = sd_reg[OUT_W];
    end

    // Two-entry output buffer.
    assign push      = en & vd_reg[OUT_W];
    assign inv_valid = (cnt_reg != 2'd0);
    assign pop       = inv_valid & ~inv_stall;
    assign inv       = buf_reg[rd_ptr_reg];
    assign cnt_next  = cnt_reg + 2'(push) - 2'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= res_item;
    end

    // The buffer never holds more than two items.
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("output buffer overfilled");

    // A singular result carries only zero entries.
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (inv_valid && inv.singular) |-> (inv.inv_r0c0 == '0 && inv.inv_r0c1 == '0 &&
        inv.inv_r0c2 == '0 && inv.inv_r1c0 == '0 && inv.inv_r1c1 == '0 &&
        inv.inv_r1c2 == '0 && inv.inv_r2c0 == '0 && inv.inv_r2c1 == '0 &&
        inv.inv_r2c2 == '0))
        else $error("singular result with nonzero entries");

    // A frozen pipeline keeps its last stage.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vd_reg[OUT_W]))
        else $error("last stage changed while frozen");

    // An item reaching the buffer when full would be lost.
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !push)
        else $error("item pushed into full buffer");

endmodule
